/* sv/crsm_pkg.sv */
// shared types and constants for the contiguous ring space manager
`default_nettype none
package crsm_pkg;

    localparam int RING_W = 17;
    localparam int OFF_W  = 16;
    localparam int ACT_W  = 3;
    localparam int SIZE_MAX_17 = 131071;

    localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_RESERVE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_COMMIT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_READ    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd4;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [RING_W-1:0] length;
    } t_cmd;

    typedef struct packed {
        logic              granted;
        logic [OFF_W-1:0]  region_offset;
        logic [RING_W-1:0] granted_length;
        logic [RING_W-1:0] used_bytes;
    } t_res;

    // ring size as seen by the core
    typedef struct packed {
        logic [RING_W-1:0] eff_size;
        logic              clear;
    } t_cfg;

endpackage
`default_nettype wire

/* sv/crsm_apb.sv */
// apb register slice holding the ring size and its clamped working copy
`default_nettype none
module crsm_apb #(
    parameter int MAX_RING_BYTES = 65536
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output crsm_pkg::t_cfg                   o_cfg
);
    import crsm_pkg::*;

    localparam int CAP     = (MAX_RING_BYTES > SIZE_MAX_17) ? SIZE_MAX_17 : MAX_RING_BYTES;
    localparam int RST_EFF = (CAP < 65536) ? CAP : 65536;
    localparam logic [RING_W-1:0] CAP_V     = RING_W'(CAP);
    localparam logic [RING_W-1:0] RST_EFF_V = RING_W'(RST_EFF);
    localparam logic [RING_W-1:0] MIN_V     = RING_W'(2);

    logic [RING_W-1:0] r_ring_size;
    logic [RING_W-1:0] r_eff_size;
    logic              r_clear;
    logic              w_wr;
    logic [RING_W-1:0] w_val;
    logic [RING_W-1:0] w_eff;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && !paddr[2];
    assign w_val  = pwdata[RING_W-1:0];

    always_comb begin
        if (w_val < MIN_V) begin
            w_eff = MIN_V;
        end else if (w_val > CAP_V) begin
            w_eff = CAP_V;
        end else begin
            w_eff = w_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size <= RING_W'(65536);
            r_eff_size  <= RST_EFF_V;
            r_clear     <= 1'b0;
        end else begin
            r_clear <= w_wr;
            if (w_wr) begin
                r_ring_size <= w_val;
                r_eff_size  <= w_eff;
            end
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {{(32-RING_W){1'b0}}, r_ring_size};

    assign o_cfg.eff_size = r_eff_size;
    assign o_cfg.clear    = r_clear;

endmodule
`default_nettype wire

/* sv/crsm_core.sv */
// ring state registers, per-action update logic and the result register
`default_nettype none
module crsm_core #(
    parameter int MAX_RING_BYTES = 65536
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire crsm_pkg::t_cfg i_cfg,
    input  wire logic           i_valid,
    input  wire crsm_pkg::t_cmd i_cmd,
    output logic                o_strobe,
    output crsm_pkg::t_res      o_res
);
    import crsm_pkg::*;

    localparam int CAP     = (MAX_RING_BYTES > SIZE_MAX_17) ? SIZE_MAX_17 : MAX_RING_BYTES;
    localparam int RST_EFF = (CAP < 65536) ? CAP : 65536;
    localparam logic [RING_W-1:0] RST_LAST_V = RING_W'(RST_EFF - 1);

    logic [RING_W-1:0] r_wr, n_wr;
    logic [RING_W-1:0] r_rd, n_rd;
    logic [RING_W-1:0] r_wrap, n_wrap;
    logic [RING_W-1:0] r_used, n_used;
    logic              r_strobe;
    t_res              r_res, n_res;

    logic [RING_W-1:0] w_size, w_last, w_len;
    logic [RING_W:0]   w_sum;
    logic [RING_W-1:0] w_tail;
    logic [RING_W-1:0] w_rd_v, w_wrap_v;
    logic [RING_W-1:0] w_req, w_span, w_glen;

    assign w_size = i_cfg.eff_size;
    assign w_last = w_size - RING_W'(1);
    assign w_len  = i_cmd.length;
    assign w_sum  = {1'b0, r_used} + {1'b0, w_len};
    assign w_tail = w_last - r_wr;

    // read side rewinds before the grant when it sits on the wrap mark
    assign w_rd_v   = (r_wrap == r_rd) ? '0 : r_rd;
    assign w_wrap_v = (r_wrap == r_rd) ? w_last : r_wrap;
    assign w_req    = (r_used > w_len) ? w_len : r_used;
    assign w_span   = (w_wrap_v >= w_rd_v) ? (w_wrap_v - w_rd_v) : '0;
    assign w_glen   = (w_req < w_span) ? w_req : w_span;

    always_comb begin
        n_wr   = r_wr;
        n_rd   = r_rd;
        n_wrap = r_wrap;
        n_used = r_used;
        n_res  = '0;
        case (i_cmd.action)
            ACT_CLEAR: begin
                n_wr   = '0;
                n_rd   = '0;
                n_wrap = w_last;
                n_used = '0;
            end
            ACT_RESERVE: begin
                if (w_sum <= {1'b0, w_size}) begin
                    n_res.granted        = 1'b1;
                    n_res.granted_length = w_len;
                    if (r_wr <= w_last && w_tail >= w_len) begin
                        n_res.region_offset = r_wr[OFF_W-1:0];
                        n_wr                = r_wr + w_len;
                    end else begin
                        // tail too short: restart at zero and mark the wrap
                        n_wrap = r_wr;
                        n_wr   = (w_len > w_last) ? w_last : w_len;
                    end
                end
            end
            ACT_COMMIT: begin
                n_used = (w_sum > {1'b0, w_size}) ? w_size : w_sum[RING_W-1:0];
            end
            ACT_READ: begin
                n_rd   = w_rd_v;
                n_wrap = w_wrap_v;
                if (r_used != '0) begin
                    n_res.granted        = 1'b1;
                    n_res.granted_length = w_glen;
                    n_res.region_offset  = w_rd_v[OFF_W-1:0];
                    n_rd                 = w_rd_v + w_glen;
                end
            end
            ACT_RELEASE: begin
                n_used = (w_len > r_used) ? '0 : (r_used - w_len);
            end
            default: begin
            end
        endcase
        n_res.used_bytes = n_used;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr     <= '0;
            r_rd     <= '0;
            r_wrap   <= RST_LAST_V;
            r_used   <= '0;
            r_strobe <= 1'b0;
        end else if (i_cfg.clear) begin
            r_wr     <= '0;
            r_rd     <= '0;
            r_wrap   <= w_last;
            r_used   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_valid;
            if (i_valid) begin
                r_wr   <= n_wr;
                r_rd   <= n_rd;
                r_wrap <= n_wrap;
                r_used <= n_used;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_res <= n_res;
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule
`default_nettype wire

/* sv/contiguous_ring_space_manager_top.sv */
// top level of the contiguous ring space manager
// Hands out contiguous byte regions of a ring (bip-buffer style offsets only).
// Command channel: drive start high with i_cmd (action, length); the
// transaction is taken at a rising edge with start high and busy low.
// busy is always low, so one command may be issued every clock cycle.
// Result channel: o_strobe is high for exactly one cycle with o_res
// (granted, region_offset, granted_length, used_bytes); the receiver must take
// it in that cycle.
// A command taken at a rising edge passes through the input register, then
// the result register, before its result shows on o_strobe and o_res.
// Throughput: one command per cycle; the only loop is the state registers
// feeding back through one pass of compare and add logic.
// Configuration: APB register 0 at byte address 0 holds ring_size; a write
// also clears the ring state in the cycle after it. Write only while idle.
// Reset: ring_size 65536 (working copy clamped to MAX_RING_BYTES), all offsets and the
// used count zero, wrap mark at the last offset, no result pending.
`default_nettype none
module contiguous_ring_space_manager_top #(
    parameter int MAX_RING_BYTES = 65536
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire crsm_pkg::t_cmd i_cmd,
    output logic                o_strobe,
    output crsm_pkg::t_res      o_res,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [2:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic      [31:0]    prdata,
    output logic                pready
);
    import crsm_pkg::*;

    t_cfg w_cfg;
    t_cmd r_cmd;
    logic r_valid;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd <= i_cmd;
        end
    end

    crsm_apb #(
        .MAX_RING_BYTES(MAX_RING_BYTES)
    ) u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    crsm_core #(
        .MAX_RING_BYTES(MAX_RING_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (r_valid),
        .i_cmd    (r_cmd),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    // a command taken outside an APB write gives a result strobe after the input and result registers
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !(psel && penable && pwrite)) |-> ##2 o_strobe)
        else $error("result missing after command");

    // used count never exceeds the working ring size
    a_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_res.used_bytes <= w_cfg.eff_size))
        else $error("used count above ring size");

    // a refused or non-region action reports an empty region
    a_nogrant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_res.granted) |->
            (o_res.region_offset == '0 && o_res.granted_length == '0))
        else $error("region reported without grant");

endmodule
`default_nettype wire
